### design/first_fit_heap_allocator_unit_defines.svh
// Assertion macros for the first-fit heap allocator.
// Used by first_fit_heap_allocator_unit.sv; no other dependencies.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FFHA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffha check failed");
// next-cycle implication
`define FFHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffha check failed");
`else
`define FFHA_ASSERT_NOW(label, clk, rst, ante, cons)
`define FFHA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### design/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
// No dependencies; used by first_fit_heap_allocator_unit.
`timescale 1ns / 1ps
package ffha_pkg;
  localparam int REQ_W  = 21;
  localparam int ADDR_W = 32;
  localparam int ST_W   = 3;
  localparam int NEED_W = 22;

  localparam logic [ADDR_W-1:0] BASE_AT_RESET = 32'd16777216;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_ZERO    = 3'd1;
  localparam logic [ST_W-1:0] ST_NOSPACE = 3'd2;
  localparam logic [ST_W-1:0] ST_BADFREE = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd4;

  typedef struct packed {
    logic              req_type;
    logic [REQ_W-1:0]  request_size;
    logic [ADDR_W-1:0] block_address;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [ADDR_W-1:0] granted_address;
  } rsp_t;
endpackage

### design/first_fit_heap_allocator_unit.sv
// Top level of the first-fit heap allocator: sequencer over a segment table.
// Depends on ffha_pkg, ffha_ram and first_fit_heap_allocator_unit_defines.svh.
//
//  channel  | signals                   | payload
//  ---------+---------------------------+----------------------
//  request  | in_valid / in_stall       | in_data  (ffha_pkg::req_t)
//  result   | out_valid / out_stall     | out_data (ffha_pkg::rsp_t)
//  config   | cfg_we                    | cfg_wdata (region base)
//
// A request scans the segments one by one (S_SCAN, S_CHK) through the single
// RAM read port, then a split or merge shifts the entries behind the hit, each
// read in S_CPRD and written in S_CPWR, before the result is registered.
// After reset the S_INIT state writes the initial free segment before requests
// are taken. One request is in work at a time; a held result stalls completion.
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_unit_defines.svh"
module first_fit_heap_allocator_unit #(
  parameter int REGION_BYTES = 1048576,
  parameter int MAX_SEGMENTS = 64,
  parameter int HEADER_BYTES = 14
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  ffha_pkg::req_t      in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ffha_pkg::rsp_t      out_data
);
  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int SW = $clog2(REGION_BYTES + 1);
  localparam int EW = SW + 1;
  localparam int NW = ffha_pkg::NEED_W;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_NEXT  = 4'd4;
  localparam logic [3:0] S_NXCHK = 4'd5;
  localparam logic [3:0] S_CPRD  = 4'd6;
  localparam logic [3:0] S_CPWR  = 4'd7;
  localparam logic [3:0] S_WRA   = 4'd8;
  localparam logic [3:0] S_WRB   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]                   state;
  logic [31:0]                  base;
  logic [CW-1:0]                count;
  logic [CW-1:0]                cnt_new;
  logic [CW-1:0]                idx;
  logic [CW-1:0]                dst;
  logic [1:0]                   k;
  logic                         dir_up;
  logic [SW-1:0]                off;
  logic                         prev_free;
  logic [SW-1:0]                prev_size;
  logic [SW-1:0]                cur_size;
  ffha_pkg::req_t               req;
  logic [NW-1:0]                need;
  logic [AW-1:0]                wa_addr;
  logic [EW-1:0]                wa_data;
  logic                         wb_en;
  logic [AW-1:0]                wb_addr;
  logic [EW-1:0]                wb_data;
  logic [ffha_pkg::ST_W-1:0]    st;
  logic [31:0]                  ga;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [EW-1:0]                ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic [EW-1:0]                ram_rdata;

  logic                         rd_free;
  logic [SW-1:0]                rd_size;
  logic [NW-1:0]                sz_ext;
  logic                         fit;
  logic [31:0]                  cur_addr;
  logic [CW-1:0]                idx_p1;
  logic [CW-1:0]                idx_m1;
  logic [CW-1:0]                src;
  logic                         cp_active;
  logic                         nf;

  ffha_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // decode the entry read back and the scan compare
  always_comb begin
    rd_free   = ram_rdata[SW];
    rd_size   = ram_rdata[SW-1:0];
    sz_ext    = NW'(rd_size);
    fit       = rd_free && ((sz_ext == need) || (sz_ext > need + NW'(HEADER_BYTES)));
    cur_addr  = base + 32'(off) + 32'(HEADER_BYTES);
    idx_p1    = idx + CW'(1);
    idx_m1    = idx - CW'(1);
    src       = dir_up ? (dst - CW'(1)) : (dst + CW'(k));
    cp_active = dir_up ? ({1'b0, dst} > {1'b0, idx_p1})
                       : ((k != 2'd0) && (({1'b0, dst} + (CW+1)'(k)) < {1'b0, count}));
    nf        = ({1'b0, idx_p1} < {1'b0, count}) && rd_free;
  end

  // table port control per sequencer step
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wa_addr;
    ram_wdata = wa_data;
    ram_raddr = idx[AW-1:0];
    case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {1'b1, SW'(REGION_BYTES)};
      end
      S_NEXT:  ram_raddr = idx_p1[AW-1:0];
      S_CPRD:  ram_raddr = src[AW-1:0];
      S_CPWR: begin
        ram_we    = 1'b1;
        ram_waddr = dst[AW-1:0];
        ram_wdata = ram_rdata;
      end
      S_WRA:   ram_we = 1'b1;
      S_WRB: begin
        ram_we    = 1'b1;
        ram_waddr = wb_addr;
        ram_wdata = wb_data;
      end
      default: ram_raddr = idx[AW-1:0];
    endcase
  end

  assign in_stall = (state != S_IDLE);

  // region base register
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= ffha_pkg::BASE_AT_RESET;
    end else if (cfg_we) begin
      base <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      count     <= CW'(1);
      out_valid <= 1'b0;
    end else begin
      // drop a result once transferred, unless a new one replaces it
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: state <= S_IDLE;
        S_IDLE: begin
          if (in_valid) begin
            req       <= in_data;
            need      <= NW'(in_data.request_size) + NW'(HEADER_BYTES);
            idx       <= '0;
            off       <= '0;
            prev_free <= 1'b0;
            ga        <= '0;
            if (in_data.req_type == ffha_pkg::REQ_ALLOC && in_data.request_size == '0) begin
              st    <= ffha_pkg::ST_ZERO;
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (idx == count) begin
            st    <= (req.req_type == ffha_pkg::REQ_ALLOC) ? ffha_pkg::ST_NOSPACE
                                                            : ffha_pkg::ST_BADFREE;
            state <= S_DONE;
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (req.req_type == ffha_pkg::REQ_ALLOC && fit) begin
            if (sz_ext == need) begin
              wa_addr <= idx[AW-1:0];
              wa_data <= {1'b0, rd_size};
              wb_en   <= 1'b0;
              cnt_new <= count;
              dir_up  <= 1'b1;
              dst     <= idx;
              st      <= ffha_pkg::ST_OK;
              ga      <= cur_addr;
              state   <= S_CPRD;
            end else if (count == CW'(MAX_SEGMENTS)) begin
              st    <= ffha_pkg::ST_FULL;
              state <= S_DONE;
            end else begin
              wa_addr <= idx_p1[AW-1:0];
              wa_data <= {1'b1, rd_size - need[SW-1:0]};
              wb_en   <= 1'b1;
              wb_addr <= idx[AW-1:0];
              wb_data <= {1'b0, need[SW-1:0]};
              cnt_new <= count + CW'(1);
              dir_up  <= 1'b1;
              dst     <= count;
              st      <= ffha_pkg::ST_OK;
              ga      <= cur_addr;
              state   <= S_CPRD;
            end
          end else if (req.req_type == ffha_pkg::REQ_FREE && !rd_free &&
                       cur_addr == req.block_address) begin
            cur_size <= rd_size;
            st       <= ffha_pkg::ST_OK;
            state    <= S_NEXT;
          end else begin
            off       <= off + rd_size;
            prev_free <= rd_free;
            prev_size <= rd_size;
            idx       <= idx_p1;
            state     <= S_SCAN;
          end
        end
        S_NEXT: state <= S_NXCHK;
        S_NXCHK: begin
          // plan the merge with any free neighbours
          dir_up <= 1'b0;
          wb_en  <= 1'b0;
          if (prev_free && nf) begin
            wa_addr <= idx_m1[AW-1:0];
            wa_data <= {1'b1, prev_size + cur_size + rd_size};
            dst     <= idx;
            k       <= 2'd2;
            cnt_new <= count - CW'(2);
          end else if (nf) begin
            wa_addr <= idx[AW-1:0];
            wa_data <= {1'b1, cur_size + rd_size};
            dst     <= idx_p1;
            k       <= 2'd1;
            cnt_new <= count - CW'(1);
          end else if (prev_free) begin
            wa_addr <= idx_m1[AW-1:0];
            wa_data <= {1'b1, prev_size + cur_size};
            dst     <= idx;
            k       <= 2'd1;
            cnt_new <= count - CW'(1);
          end else begin
            wa_addr <= idx[AW-1:0];
            wa_data <= {1'b1, cur_size};
            dst     <= idx;
            k       <= 2'd0;
            cnt_new <= count;
          end
          state <= S_CPRD;
        end
        S_CPRD: state <= cp_active ? S_CPWR : S_WRA;
        S_CPWR: begin
          dst   <= dir_up ? (dst - CW'(1)) : (dst + CW'(1));
          state <= S_CPRD;
        end
        S_WRA: begin
          count <= cnt_new;
          state <= wb_en ? S_WRB : S_DONE;
        end
        S_WRB: state <= S_DONE;
        S_DONE: begin
          // hold until the result register is free
          if (!out_valid || !out_stall) begin
            out_valid                <= 1'b1;
            out_data.status          <= st;
            out_data.granted_address <= ga;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FFHA_ASSERT_NOW(a_count_range, clk, rst, 1'b1,
    (count != '0) && (count <= CW'(MAX_SEGMENTS)))
  `FFHA_ASSERT_NOW(a_fail_no_addr, clk, rst,
    out_valid && (out_data.status != ffha_pkg::ST_OK), out_data.granted_address == '0)
  `FFHA_ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && !in_stall, in_stall)
endmodule

### design/ffha_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module ffha_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
